// ----- rtl/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcc_pkg: shared definitions for the text console cursor control
// Transaction payloads, action and command codes, register map, colour palette.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int MAX_COLS_DEF = 511;
  localparam int MAX_ROWS_DEF = 255;

  localparam int COLS_REG_W = 9;
  localparam int ROWS_REG_W = 8;
  localparam logic [COLS_REG_W-1:0] COLS_RESET = 9'd80;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 8'd30;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic [1:0] ACT_STREAM = 2'd0;
  localparam logic [1:0] ACT_PUT    = 2'd1;
  localparam logic [1:0] ACT_CURSOR = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [2:0] CMD_GLYPH  = 3'd0;
  localparam logic [2:0] CMD_SCROLL = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_ERASE  = 3'd3;
  localparam logic [2:0] CMD_BAR    = 3'd4;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [23:0] GREY = 24'hc8c8c8;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [7:0] cell_row;
    logic [8:0] cell_col;
    logic       show_cursor;
  } item_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  out_row;
    logic [8:0]  out_col;
    logic [7:0]  glyph;
    logic [23:0] fore_rgb;
    logic [23:0] back_rgb;
    logic        last;
  } result_t;

  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000aa;
      4'd2:    rgb = 24'h00aa00;
      4'd3:    rgb = 24'h00aaaa;
      4'd4:    rgb = 24'haa0000;
      4'd5:    rgb = 24'haa00aa;
      4'd6:    rgb = 24'haa5500;
      4'd7:    rgb = 24'haaaaaa;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'h5555ff;
      4'd10:   rgb = 24'h55ff55;
      4'd11:   rgb = 24'h55ffff;
      4'd12:   rgb = 24'hff5555;
      4'd13:   rgb = 24'hff55ff;
      4'd14:   rgb = 24'hffff55;
      default: rgb = 24'hffffff;
    endcase
    return rgb;
  endfunction

endpackage

// ----- rtl/tcc_chan_if.sv -----
// ----------------------------------------------------------------------------
// tcc_chan_if: valid/ready channel
// Carries one payload per transaction, accepted when valid and ready are high.
// ----------------------------------------------------------------------------
interface tcc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/text_console_cursor_control_top.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_control_top: cursor and typing logic of a text console
// Turns stream, put, cursor and clear actions into drawing commands.
// ----------------------------------------------------------------------------
// On acceptance, an action's drawing commands (none, one or two) are worked
// out from it and the typing and cursor state and pushed into a four-entry
// result queue; with the queue empty, the first appears on the result channel
// in the next cycle. The result channel hands over one command per cycle while
// ready is high, so actions of at most one command can be accepted every cycle
// and two-command actions fill the queue. The item channel is ready while the
// queue has room for two commands. The user must write registers over the APB
// port only while no action is in flight; the block does not enforce it.
module text_console_cursor_control_top #(
  parameter int MAX_COLS = tcc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcc_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  tcc_chan_if.sink                        item,
  tcc_chan_if.source                      result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int ColsW = $clog2(MAX_COLS + 1);
  localparam int CxW   = (ColsW > 10) ? ColsW : 10;
  localparam int RowsW = $clog2(MAX_ROWS + 1);
  localparam int CyW   = (RowsW > 10) ? RowsW : 10;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // configuration registers
  logic [tcc_pkg::COLS_REG_W-1:0] text_columns;
  logic [tcc_pkg::ROWS_REG_W-1:0] text_rows;
  logic                           cfg_write;

  // console state
  logic [8:0] type_col;
  logic [7:0] type_row;
  logic       bar_valid;
  logic [7:0] bar_row;
  logic [8:0] bar_col;

  logic [8:0] type_col_next;
  logic [7:0] type_row_next;
  logic       bar_valid_next;
  logic [7:0] bar_row_next;
  logic [8:0] bar_col_next;

  // result queue
  tcc_pkg::result_t   queue [QDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCntW-1:0]   count;

  logic               accept;
  logic               pop;
  logic [1:0]         push_n;

  // combinational work
  tcc_pkg::item_t     it;
  logic [CxW-1:0]     cols;
  logic [CyW-1:0]     rows;
  logic [CxW-1:0]     cx;
  logic [CxW-1:0]     tab_sum;
  logic [CyW-1:0]     cy;
  logic               target_ok;
  logic               c0_vld;
  logic               c1_vld;
  tcc_pkg::result_t   c0;
  tcc_pkg::result_t   c1;
  tcc_pkg::result_t   first;
  tcc_pkg::result_t   second;

  // apb register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == tcc_pkg::REG_ROWS) ?
                     {24'd0, text_rows} : {23'd0, text_columns};

  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns <= tcc_pkg::COLS_RESET;
      text_rows    <= tcc_pkg::ROWS_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == tcc_pkg::REG_COLUMNS) begin
        text_columns <= pwdata[tcc_pkg::COLS_REG_W-1:0];
      end else begin
        text_rows <= pwdata[tcc_pkg::ROWS_REG_W-1:0];
      end
    end
  end

  // handshakes
  assign it           = item.payload;
  assign item.ready   = (count <= QCntW'(QDepth - 2));
  assign accept       = item.valid && item.ready;
  assign result.valid = (count != '0);
  assign result.payload = queue[rd_ptr];
  assign pop          = result.valid && result.ready;

  // screen size clamped to the build limits
  always_comb begin
    cols = CxW'(text_columns);
    if (cols > CxW'(MAX_COLS)) begin
      cols = CxW'(MAX_COLS);
    end
    rows = CyW'(text_rows);
    if (rows > CyW'(MAX_ROWS)) begin
      rows = CyW'(MAX_ROWS);
    end
  end

  assign target_ok = (CyW'(it.cell_row) < rows) && (CxW'(it.cell_col) < cols);
  assign tab_sum   = CxW'(type_col) + CxW'(8);

  always_comb begin
    c0     = '0;
    c1     = '0;
    c0_vld = 1'b0;
    c1_vld = 1'b0;
    cx     = CxW'(type_col);
    cy     = CyW'(type_row);
    type_col_next  = type_col;
    type_row_next  = type_row;
    bar_valid_next = bar_valid;
    bar_row_next   = bar_row;
    bar_col_next   = bar_col;
    case (it.action)
      tcc_pkg::ACT_STREAM: begin
        c0.command = tcc_pkg::CMD_GLYPH;
        c0.out_row = type_row;
        c0.out_col = type_col;
        case (it.char_code)
          tcc_pkg::CH_LF: begin
            cx = '0;
            cy = cy + CyW'(1);
          end
          tcc_pkg::CH_CR: begin
            cx = '0;
          end
          tcc_pkg::CH_BS: begin
            if (type_col != '0) begin
              cx          = cx - CxW'(1);
              c0_vld      = 1'b1;
              c0.out_col  = type_col - 9'd1;
              c0.glyph    = tcc_pkg::CH_SPACE;
              c0.fore_rgb = tcc_pkg::GREY;
            end
          end
          tcc_pkg::CH_TAB: begin
            cx = {tab_sum[CxW-1:3], 3'b000};
          end
          default: begin
            c0_vld      = 1'b1;
            c0.glyph    = it.char_code;
            c0.fore_rgb = tcc_pkg::palette(it.attribute[3:0]);
            cx          = cx + CxW'(1);
          end
        endcase
        // wrap then scroll
        if (cx >= cols) begin
          cx = '0;
          cy = cy + CyW'(1);
        end
        if (cy >= rows) begin
          c1_vld     = 1'b1;
          c1.command = tcc_pkg::CMD_SCROLL;
          cy = (rows == '0) ? '0 : rows - CyW'(1);
        end
        type_col_next = cx[8:0];
        type_row_next = cy[7:0];
      end
      tcc_pkg::ACT_PUT: begin
        c0_vld      = target_ok;
        c0.command  = tcc_pkg::CMD_GLYPH;
        c0.out_row  = it.cell_row;
        c0.out_col  = it.cell_col;
        c0.glyph    = (it.char_code != '0) ? it.char_code : tcc_pkg::CH_SPACE;
        c0.fore_rgb = tcc_pkg::palette(it.attribute[3:0]);
        c0.back_rgb = tcc_pkg::palette(it.attribute[7:4]);
        if (target_ok && bar_valid && bar_row == it.cell_row
            && bar_col == it.cell_col) begin
          bar_valid_next = 1'b0;
        end
      end
      tcc_pkg::ACT_CURSOR: begin
        c0_vld = bar_valid && (bar_row != it.cell_row || bar_col != it.cell_col
                               || !it.show_cursor);
        c0.command  = tcc_pkg::CMD_ERASE;
        c0.out_row  = bar_row;
        c0.out_col  = bar_col;
        c1_vld      = it.show_cursor && target_ok;
        c1.command  = tcc_pkg::CMD_BAR;
        c1.out_row  = it.cell_row;
        c1.out_col  = it.cell_col;
        c1.fore_rgb = tcc_pkg::GREY;
        if (c0_vld) begin
          bar_valid_next = 1'b0;
        end
        if (c1_vld) begin
          bar_valid_next = 1'b1;
          bar_row_next   = it.cell_row;
          bar_col_next   = it.cell_col;
        end
      end
      default: begin
        c0_vld        = 1'b1;
        c0.command    = tcc_pkg::CMD_CLEAR;
        type_col_next = '0;
        type_row_next = '0;
      end
    endcase
  end

  // pack the valid commands in order, last flag on the final one
  always_comb begin
    push_n = {1'b0, c0_vld} + {1'b0, c1_vld};
    first  = c0_vld ? c0 : c1;
    second = c1;
    first.last  = (push_n == 2'd1);
    second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      type_col  <= '0;
      type_row  <= '0;
      bar_valid <= 1'b0;
      bar_row   <= '0;
      bar_col   <= '0;
    end else if (accept) begin
      type_col  <= type_col_next;
      type_row  <= type_row_next;
      bar_valid <= bar_valid_next;
      bar_row   <= bar_row_next;
      bar_col   <= bar_col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + QPtrW'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      count <= count + (accept ? QCntW'(push_n) : QCntW'(0)) - QCntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push_n != 2'd0) begin
      queue[wr_ptr] <= first;
    end
    if (accept && push_n == 2'd2) begin
      queue[wr_ptr + QPtrW'(1)] <= second;
    end
  end

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    accept && it.action == tcc_pkg::ACT_CLEAR |=> type_col == '0 && type_row == '0)
    else $error("clear did not home the typing position");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    pop && !result.payload.last |=> result.valid)
    else $error("second command of a transaction missing");

endmodule
